// ----- src/icta_pkg.sv -----
// ----------------------------------------------------------------------------
// icta_pkg: shared types and constants of the tilt code to angle converter
// Fixed field widths, register indexes, fir taps and the arcsine table builder.
// ----------------------------------------------------------------------------
package icta_pkg;

  // fixed field widths
  localparam int ANGLE_W   = 16;
  localparam int ROM_W     = 15;
  localparam int TRIM_W    = 8;
  localparam int TAP_W     = 13;
  localparam int TAP_IDX_W = 5;
  localparam int PROD_W    = ANGLE_W + TAP_W + 1;
  localparam int SUM_W     = 40;
  localparam int FRAC_W    = 16;

  // apb port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // arithmetic constants
  localparam int unsigned QUARTER_TURN  = 23040;
  localparam int unsigned ROUND_HALF    = 32768;
  localparam int unsigned SENS_NOM      = 1638;
  localparam int unsigned SENS_NOM_BITS = 11;
  localparam logic [63:0] PI_Q30        = 64'd3373259426;

  // divider digits retired per cycle
  localparam int DIV_STEP = 4;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  typedef enum logic [2:0] {
    REG_ZERO_CODE   = 3'd0,
    REG_TRIM_AXIS_A = 3'd1,
    REG_TRIM_AXIS_B = 3'd2,
    REG_FOLD_HIGH   = 3'd3,
    REG_FOLD_LOW    = 3'd4,
    REG_SENSITIVITY = 3'd5,
    REG_FILTER_ON   = 3'd6
  } reg_index_t;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_MUL,
    ST_ACC
  } back_state_t;

  // per-sample flags carried from front to back
  typedef struct packed {
    logic neg;
    logic sat;
    logic axis;
  } sample_flags_t;

  // q16 symmetric fir taps, zero past the seventeenth
  function automatic logic [TAP_W-1:0] fir_tap(input logic [TAP_IDX_W-1:0] idx);
    logic [TAP_W-1:0] tap;
    unique case (idx)
      5'd0, 5'd16: tap = 13'd3313;
      5'd1, 5'd15: tap = 13'd3506;
      5'd2, 5'd14: tap = 13'd3680;
      5'd3, 5'd13: tap = 13'd3832;
      5'd4, 5'd12: tap = 13'd3960;
      5'd5, 5'd11: tap = 13'd4062;
      5'd6, 5'd10: tap = 13'd4136;
      5'd7, 5'd9:  tap = 13'd4180;
      5'd8:        tap = 13'd4195;
      default:     tap = '0;
    endcase
    return tap;
  endfunction

  // q30 sine of an angle in 1/256 degree, taylor series to the 15th power
  function automatic longint sine_q30(input int unsigned a);
    logic [63:0] t;
    logic [63:0] term;
    longint acc;
    t = (64'(a) * PI_Q30) / 64'd46080;
    term = t;
    acc = longint'(t);
    term = (term * t) >> 30;
    term = ((term * t) >> 30) / 64'd6;
    acc -= longint'(term);
    term = (term * t) >> 30;
    term = ((term * t) >> 30) / 64'd20;
    acc += longint'(term);
    term = (term * t) >> 30;
    term = ((term * t) >> 30) / 64'd42;
    acc -= longint'(term);
    term = (term * t) >> 30;
    term = ((term * t) >> 30) / 64'd72;
    acc += longint'(term);
    term = (term * t) >> 30;
    term = ((term * t) >> 30) / 64'd110;
    acc -= longint'(term);
    term = (term * t) >> 30;
    term = ((term * t) >> 30) / 64'd156;
    acc += longint'(term);
    term = (term * t) >> 30;
    term = ((term * t) >> 30) / 64'd210;
    acc -= longint'(term);
    return acc;
  endfunction

  // arcsine table entry: angle whose sine is nearest to idx / depth
  function automatic int unsigned asin_entry(input int unsigned idx, input int unsigned depth);
    longint num;
    longint dep;
    longint s0;
    longint s1;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    num = longint'(64'(idx) << 30);
    dep = longint'(depth);
    lo = 0;
    hi = QUARTER_TURN;
    // bisection for the largest angle with sine not above the target
    for (int n = 0; n < 16; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (sine_q30(mid) * dep <= num) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    // step up when the next angle is strictly nearer
    if (lo < QUARTER_TURN) begin
      s0 = sine_q30(lo);
      s1 = sine_q30(lo + 1);
      if (num >= (((s0 + s1) >>> 1) + 1) * dep) begin
        lo = lo + 1;
      end
    end
    return lo;
  endfunction

endpackage

// ----- src/icta_queue.sv -----
// ----------------------------------------------------------------------------
// icta_queue: short fifo between front and back
// Lets the front keep accepting while the back works on a sample.
// ----------------------------------------------------------------------------
module icta_queue
  import icta_pkg::*;
#(
  parameter int Width = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [Width-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  logic [Width-1:0] mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW:0]    count;

  assign push_ready = (count != (PtrW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if ((push && push_ready) && !(pop && pop_valid)) begin
        count <= count + 1'b1;
      end else if (!(push && push_ready) && (pop && pop_valid)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/icta_front.sv -----
// ----------------------------------------------------------------------------
// icta_front: input stage of the tilt code to angle converter
// Registers a code, folds it at the limits, removes the offset and trim,
// and hands magnitude, sign, clamp flag and axis to the queue.
// ----------------------------------------------------------------------------
module icta_front
  import icta_pkg::*;
#(
  parameter int CodeBits = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CodeBits-1:0] raw_code,
  input  logic                axis_select,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CodeBits-1:0] zero_code,
  input  logic [TRIM_W-1:0]   trim_axis_a,
  input  logic [TRIM_W-1:0]   trim_axis_b,
  input  logic [CodeBits-1:0] fold_high,
  input  logic [CodeBits-1:0] fold_low,
  input  logic [CodeBits-1:0] sensitivity,
  output logic                push,
  input  logic                push_ready,
  output logic [CodeBits+1:0] push_mag,
  output sample_flags_t       push_flags
);

  localparam int RW   = CodeBits + 3;
  localparam int MagW = CodeBits + 2;

  logic                st_valid;
  logic [CodeBits-1:0] st_code;
  logic                st_axis;

  logic signed [RW-1:0] code_s;
  logic signed [RW-1:0] hi_s;
  logic signed [RW-1:0] lo_s;
  logic signed [RW-1:0] folded;
  logic signed [RW-1:0] offset;
  logic signed [RW-1:0] diff;
  logic [TRIM_W-1:0]    trim;
  logic [RW-1:0]        mag_full;
  logic [CodeBits-1:0]  sens_eff;

  assign in_ready = !st_valid || push_ready;
  assign push     = st_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_valid <= 1'b1;
    end else if (push && push_ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_code <= raw_code;
      st_axis <= axis_select;
    end
  end

  // fold about the limits, full signed precision
  always_comb begin
    code_s = signed'({3'b000, st_code});
    hi_s   = signed'({3'b000, fold_high});
    lo_s   = signed'({3'b000, fold_low});
    priority if (code_s > hi_s) begin
      folded = (hi_s <<< 1) - code_s;
    end else if (code_s < lo_s) begin
      folded = (lo_s <<< 1) - code_s;
    end else begin
      folded = code_s;
    end
  end

  // offset removal and magnitude
  always_comb begin
    trim     = st_axis ? trim_axis_b : trim_axis_a;
    offset   = signed'({3'b000, zero_code}) + signed'({{(RW - TRIM_W){trim[TRIM_W-1]}}, trim});
    diff     = folded - offset;
    mag_full = (diff < 0) ? RW'(-diff) : RW'(diff);
    sens_eff = (sensitivity == '0) ? CodeBits'(1) : sensitivity;
  end

  assign push_mag        = mag_full[MagW-1:0];
  assign push_flags.neg  = (diff < 0);
  assign push_flags.sat  = (mag_full[MagW-1:0] > {2'b00, sens_eff});
  assign push_flags.axis = st_axis;

endmodule

// ----- src/icta_div.sv -----
// ----------------------------------------------------------------------------
// icta_div: iterative restoring divider
// Retires DIV_STEP quotient bits per cycle; the numerator must be below
// den * 2^QuotW.
// ----------------------------------------------------------------------------
module icta_div
  import icta_pkg::*;
#(
  parameter int DenW  = 12,
  parameter int QuotW = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [QuotW+DenW-1:0]  num,
  input  logic [DenW-1:0]        den,
  output logic                   done,
  output logic [QuotW-1:0]       quot
);

  localparam int Iters = QuotW / DIV_STEP;
  localparam int CntW  = (Iters > 1) ? $clog2(Iters) : 1;

  logic              busy;
  logic [CntW-1:0]   cnt;
  logic [DenW-1:0]   rem;
  logic [DenW-1:0]   den_r;
  logic [DenW-1:0]   rem_next;
  logic [QuotW-1:0]  quot_next;

  assign done = busy && (cnt == CntW'(Iters - 1));

  // DIV_STEP shift and subtract steps
  always_comb begin
    logic [DenW:0]    trial;
    logic [DenW-1:0]  r;
    logic [QuotW-1:0] q;
    r = rem;
    q = quot;
    for (int s = 0; s < DIV_STEP; s++) begin
      trial = {r, q[QuotW-1]};
      q = {q[QuotW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        q[0] = 1'b1;
      end
      r = trial[DenW-1:0];
    end
    rem_next  = r;
    quot_next = q;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[QuotW +: DenW];
      quot  <= num[QuotW-1:0];
      den_r <= den;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

endmodule

// ----- src/icta_back.sv -----
// ----------------------------------------------------------------------------
// icta_back: back end of the tilt code to angle converter
// Divides by the sensitivity unless clamped, looks up the arcsine and, with
// the filter on, fir-weights and sums the window; holds the result register.
// ----------------------------------------------------------------------------
module icta_back
  import icta_pkg::*;
#(
  parameter int TapCount  = 17,
  parameter int CodeBits  = 11,
  parameter int AsinDepth = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  logic [CodeBits+1:0]        q_mag,
  input  sample_flags_t              q_flags,
  output logic                       q_pop,
  input  logic [CodeBits-1:0]        sensitivity,
  input  logic                       filter_on,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [ANGLE_W-1:0]  angle_value,
  output logic                       axis_out,
  output logic                       saturated
);

  localparam int QW   = $clog2(AsinDepth + 1);
  localparam int QWP  = ((QW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int DenW = CodeBits + 1;
  localparam int NumW = QWP + DenW;
  localparam int TiW  = $clog2(TapCount + 1);
  localparam logic signed [SUM_W-1:0] MaxAngle  = SUM_W'(QUARTER_TURN);
  localparam logic signed [SUM_W-1:0] MinAngle  = -SUM_W'(QUARTER_TURN);
  localparam logic signed [SUM_W-1:0] RoundHalf = SUM_W'(ROUND_HALF);

  back_state_t state;
  back_state_t state_next;

  // arcsine rom, built at elaboration
  logic [ROM_W-1:0] asin_rom [AsinDepth+1];
  for (genvar g = 0; g <= AsinDepth; g++) begin : g_rom
    assign asin_rom[g] = ROM_W'(asin_entry(g, AsinDepth));
  end

  logic [CodeBits-1:0] sens_eff;
  logic [NumW-1:0]     div_num;
  logic                div_start;
  logic                div_done;
  logic [QWP-1:0]      div_quot;

  sample_flags_t            cur_flags;
  logic [ROM_W-1:0]         rom_data;
  logic [QW-1:0]            rom_addr;
  logic signed [ANGLE_W-1:0] angle_w;
  logic signed [ANGLE_W-1:0] angle_r;
  logic signed [TAP_W:0]    tap_s;
  logic signed [PROD_W-1:0] prod;
  logic                     restart_w;
  logic                     restart;
  logic [TiW-1:0]           tap_sel;

  logic [TiW-1:0]           tap_index;
  logic signed [SUM_W-1:0]  weighted_sum;
  logic                     window_axis;
  logic                     window_clamped;

  logic signed [SUM_W-1:0]  sum_w;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [ANGLE_W-1:0] res_w;
  logic [TiW-1:0]           cnt_w;
  logic                     clamp_w;
  logic                     axis_w;
  logic                     win_full;
  logic                     need_out;
  logic                     acc_done;
  logic                     load_out;

  // divider operands: round(mag * depth / sens) as (2 mag depth + sens) / 2 sens
  assign sens_eff = (sensitivity == '0) ? CodeBits'(1) : sensitivity;
  assign div_num  = NumW'(q_mag) * NumW'(2 * AsinDepth) + NumW'(sens_eff);

  icta_div #(
    .DenW  (DenW),
    .QuotW (QWP)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({sens_eff, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

  // window accumulate and rounding
  always_comb begin
    sum_w    = (restart ? '0 : weighted_sum) + SUM_W'(prod);
    cnt_w    = (restart ? '0 : tap_index) + 1'b1;
    clamp_w  = (restart ? 1'b0 : window_clamped) | cur_flags.sat;
    axis_w   = (restart || (tap_index == '0)) ? cur_flags.axis : window_axis;
    win_full = (cnt_w == TiW'(TapCount));
    need_out = !filter_on || win_full;
    rnd      = (sum_w + RoundHalf) >>> FRAC_W;
    priority if (rnd > MaxAngle) begin
      res_w = ANGLE_W'(QUARTER_TURN);
    end else if (rnd < MinAngle) begin
      res_w = -ANGLE_W'(QUARTER_TURN);
    end else begin
      res_w = rnd[ANGLE_W-1:0];
    end
  end

  assign acc_done = !need_out || !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = q_flags.sat ? ST_LOOK : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (acc_done) begin
          if (q_valid) begin
            state_next = q_flags.sat ? ST_LOOK : ST_DIV;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
      end
      ST_ACC: begin
        q_pop    = q_valid && acc_done;
        load_out = need_out && acc_done;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign div_start = q_pop && !q_flags.sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // rom read and multiply
  assign rom_addr  = cur_flags.sat ? QW'(AsinDepth) : div_quot[QW-1:0];
  assign angle_w   = cur_flags.neg ? -signed'({1'b0, rom_data}) : signed'({1'b0, rom_data});
  assign restart_w = (tap_index != '0) && (cur_flags.axis != window_axis);
  assign tap_sel   = restart_w ? '0 : tap_index;
  assign tap_s     = signed'({1'b0, fir_tap(TAP_IDX_W'(tap_sel))});

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_flags <= q_flags;
    end
    if (state == ST_LOOK) begin
      rom_data <= asin_rom[rom_addr];
    end
    if (state == ST_MUL) begin
      angle_r <= angle_w;
      prod    <= angle_w * tap_s;
      restart <= restart_w;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_index      <= '0;
      weighted_sum   <= '0;
      window_axis    <= 1'b0;
      window_clamped <= 1'b0;
    end else if ((state == ST_ACC) && acc_done) begin
      if (need_out) begin
        tap_index      <= '0;
        weighted_sum   <= '0;
        window_axis    <= 1'b0;
        window_clamped <= 1'b0;
      end else begin
        tap_index      <= cnt_w;
        weighted_sum   <= sum_w;
        window_axis    <= axis_w;
        window_clamped <= clamp_w;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (!filter_on) begin
        angle_value <= angle_r;
        axis_out    <= cur_flags.axis;
        saturated   <= cur_flags.sat;
      end else begin
        angle_value <= res_w;
        axis_out    <= axis_w;
        saturated   <= clamp_w;
      end
    end
  end

endmodule

// ----- src/inclinometer_code_to_angle_fir_core.sv -----
// ----------------------------------------------------------------------------
// inclinometer_code_to_angle_fir_core: tilt sensor code to angle in degrees
// Folds, offsets and scales a sensor code, takes the arcsine from a rom and
// optionally averages a window of angles with a symmetric fir.
//
// Usage:
//   input channel (in_valid/in_ready): raw_code and axis_select, one sample
//   per transfer. output channel (out_valid/out_ready): angle_value in
//   1/256 degree, axis_out and saturated. With filter_on set, one result
//   comes per TAP_COUNT samples of one axis; a change of axis restarts the
//   window. With filter_on clear, every sample gives a result.
//   Configuration goes through the apb port, registers at 4*index; write
//   it only while no sample is in flight.
// Flow:
//   the back end takes one sample at a time through the iterative divider,
//   rom read, multiply and accumulate; a clamped ratio skips the divider.
//   The result register loads in the accumulate step of the last sample
//   of a window, or of every sample with filter_on clear.
//   A two-entry queue and the input register absorb samples while the back
//   end works; a stalled receiver holds the result register and then the
//   back end, and in_ready drops once the queue and input register fill.
// Reset: clears the window, queue and result register; registers go to
//   their defaults.
// ----------------------------------------------------------------------------
module inclinometer_code_to_angle_fir_core
  import icta_pkg::*;
#(
  parameter int TAP_COUNT        = 17,
  parameter int CODE_BITS        = 11,
  parameter int ASIN_TABLE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  logic [CODE_BITS-1:0]       raw_code,
  input  logic                       axis_select,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic signed [ANGLE_W-1:0]  angle_value,
  output logic                       axis_out,
  output logic                       saturated,
  output logic                       out_valid,
  input  logic                       out_ready
);

  localparam int MagW = CODE_BITS + 2;
  localparam logic [CODE_BITS-1:0] ZeroReset =
    CODE_BITS'(1 << (CODE_BITS - 1));
  localparam logic [CODE_BITS-1:0] SensReset =
    CODE_BITS'((SENS_NOM * (1 << CODE_BITS)) / (1 << SENS_NOM_BITS));

  logic [CODE_BITS-1:0] zero_code;
  logic [TRIM_W-1:0]    trim_axis_a;
  logic [TRIM_W-1:0]    trim_axis_b;
  logic [CODE_BITS-1:0] fold_high;
  logic [CODE_BITS-1:0] fold_low;
  logic [CODE_BITS-1:0] sensitivity;
  logic                 filter_on;

  logic [2:0]           reg_idx;

  logic                 push;
  logic                 push_ready;
  logic [MagW-1:0]      push_mag;
  sample_flags_t        push_flags;
  logic                 q_pop;
  logic                 q_valid;
  logic [MagW+2:0]      q_data;
  sample_flags_t        q_flags;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_code   <= ZeroReset;
      trim_axis_a <= '0;
      trim_axis_b <= '0;
      fold_high   <= '1;
      fold_low    <= '0;
      sensitivity <= SensReset;
      filter_on   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_ZERO_CODE:   zero_code   <= pwdata[CODE_BITS-1:0];
        REG_TRIM_AXIS_A: trim_axis_a <= pwdata[TRIM_W-1:0];
        REG_TRIM_AXIS_B: trim_axis_b <= pwdata[TRIM_W-1:0];
        REG_FOLD_HIGH:   fold_high   <= pwdata[CODE_BITS-1:0];
        REG_FOLD_LOW:    fold_low    <= pwdata[CODE_BITS-1:0];
        REG_SENSITIVITY: sensitivity <= pwdata[CODE_BITS-1:0];
        REG_FILTER_ON:   filter_on   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_ZERO_CODE:   prdata = DATA_W'(zero_code);
      REG_TRIM_AXIS_A: prdata = DATA_W'(trim_axis_a);
      REG_TRIM_AXIS_B: prdata = DATA_W'(trim_axis_b);
      REG_FOLD_HIGH:   prdata = DATA_W'(fold_high);
      REG_FOLD_LOW:    prdata = DATA_W'(fold_low);
      REG_SENSITIVITY: prdata = DATA_W'(sensitivity);
      REG_FILTER_ON:   prdata = DATA_W'(filter_on);
      default:         prdata = '0;
    endcase
  end

  // front: fold, offset, magnitude
  icta_front #(
    .CodeBits (CODE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .raw_code    (raw_code),
    .axis_select (axis_select),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .zero_code   (zero_code),
    .trim_axis_a (trim_axis_a),
    .trim_axis_b (trim_axis_b),
    .fold_high   (fold_high),
    .fold_low    (fold_low),
    .sensitivity (sensitivity),
    .push        (push),
    .push_ready  (push_ready),
    .push_mag    (push_mag),
    .push_flags  (push_flags)
  );

  // queue between front and back
  icta_queue #(
    .Width (MagW + 3)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_mag, push_flags}),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  assign q_flags = q_data[2:0];

  // back: divide, arcsine, fir
  icta_back #(
    .TapCount  (TAP_COUNT),
    .CodeBits  (CODE_BITS),
    .AsinDepth (ASIN_TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_mag       (q_data[MagW+2:3]),
    .q_flags     (q_flags),
    .q_pop       (q_pop),
    .sensitivity (sensitivity),
    .filter_on   (filter_on),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .angle_value (angle_value),
    .axis_out    (axis_out),
    .saturated   (saturated)
  );

endmodule

// ----- src/icta_checker.sv -----
// ----------------------------------------------------------------------------
// icta_checker: port-level checks for the tilt code to angle converter
// Watches the result channel and the reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module icta_checker
  import icta_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [ANGLE_W-1:0] angle_value,
  input logic                      axis_out,
  input logic                      saturated
);

  localparam logic signed [ANGLE_W-1:0] MaxAngle = ANGLE_W'(QUARTER_TURN);
  localparam logic signed [ANGLE_W-1:0] MinAngle = -ANGLE_W'(QUARTER_TURN);

  // every presented angle stays within a quarter turn
  a_angle_range: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> ((angle_value <= MaxAngle) && (angle_value >= MinAngle))
  ) else $error("angle_value outside +-90 degrees");

  // a stalled result holds until its transfer
  a_result_hold: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(angle_value) &&
                                   $stable(axis_out) && $stable(saturated))
  ) else $error("result changed while stalled");

  // reset empties the pipeline and reopens the input
  a_reset_clear: assert property (
    @(posedge clk)
    (!rst && $past(rst)) |-> (!out_valid && in_ready)
  ) else $error("pipeline not cleared by reset");

endmodule

bind inclinometer_code_to_angle_fir_core icta_checker u_icta_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .angle_value (angle_value),
  .axis_out    (axis_out),
  .saturated   (saturated)
);

// ----- tb/sv/inclinometer_code_to_angle_fir_core_tb.sv -----
// ----------------------------------------------------------------------------
// inclinometer_code_to_angle_fir_core_tb: self-checking bench of the tilt core
// Sends sensor codes through the valid/ready input channel with random gaps,
// stalls the result channel at random, and checks every angle, axis and
// saturation flag against an in-bench model of fold, offset, arcsine lookup
// and the 17-tap window average. Settings are changed over apb between
// phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module inclinometer_code_to_angle_fir_core_tb;
  import icta_pkg::*;

  localparam int LUT_DEPTH  = 256;
  localparam int TAPS       = 17;
  localparam int REG_COUNT  = 7;
  localparam int CODE_MAX   = 2047;
  localparam int SETTLE     = 40;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 150;

  // q16 window weights, symmetric about the center tap
  localparam int WEIGHTS[TAPS] = '{3313, 3506, 3680, 3832, 3960, 4062, 4136, 4180,
                                   4195, 4180, 4136, 4062, 3960, 3832, 3680, 3506,
                                   3313};

  typedef struct packed {
    logic [10:0] code;
    logic        axis;
  } tilt_sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      axis;
    logic                      sat;
  } tilt_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic [10:0]               raw_code = '0;
  logic                      axis_select = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] angle_value;
  logic                      axis_out;
  logic                      saturated;
  logic                      out_valid;
  logic                      out_ready = 1'b0;

  // settings as the model sees them
  logic [10:0]       zero_code_q = 11'd1024;
  logic signed [7:0] trim_a_q = '0;
  logic signed [7:0] trim_b_q = '0;
  logic [10:0]       fold_high_q = 11'd2047;
  logic [10:0]       fold_low_q = '0;
  logic [10:0]       sens_q = 11'd1638;
  logic              filter_q = 1'b1;

  // window state of the model
  int     taps_seen = 0;
  longint win_sum = 0;
  logic   win_axis = 1'b0;
  logic   win_sat = 1'b0;

  int           asin_lut[LUT_DEPTH+1];
  tilt_sample_t sample_q[$];
  tilt_result_t angle_expect_q[$];
  tilt_sample_t next_sample;
  tilt_result_t got_result;
  tilt_result_t want_result;

  logic sample_done = 1'b0;
  logic pace_on = 1'b1;
  int   send_gap = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   errors = 0;
  int   samples_taken = 0;
  int   results_checked = 0;
  int   sat_results = 0;
  int   reg_writes = 0;

  inclinometer_code_to_angle_fir_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .raw_code    (raw_code),
    .axis_select (axis_select),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .angle_value (angle_value),
    .axis_out    (axis_out),
    .saturated   (saturated),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  always #1 clk = ~clk;

  // q30 sine by taylor series, angle in 1/256 degree
  function automatic longint sine_q30_est(input int unsigned ang);
    logic [63:0] t;
    logic [63:0] term;
    longint      acc;
    t = (64'(ang) * PI_Q30) / 64'd46080;
    term = t;
    acc = longint'(t);
    for (int k = 1; k <= 7; k++) begin
      term = (term * t) >> 30;
      term = ((term * t) >> 30) / 64'(2 * k * (2 * k + 1));
      if (k % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    return acc;
  endfunction

  // arcsine table: nearest angle whose sine matches i / depth
  task automatic fill_asin_lut();
    longint      target;
    longint      err_lo;
    longint      err_hi;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    for (int i = 0; i <= LUT_DEPTH; i++) begin
      target = longint'((64'(i) << 30) / 64'(LUT_DEPTH));
      lo = 0;
      hi = QUARTER_TURN;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (sine_q30_est(mid) <= target) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      if (lo < QUARTER_TURN) begin
        err_lo = target - sine_q30_est(lo);
        err_hi = sine_q30_est(lo + 1) - target;
        if (err_hi < err_lo) begin
          lo++;
        end
      end
      asin_lut[i] = int'(lo);
    end
  endtask

  function automatic void clear_window();
    taps_seen = 0;
    win_sum = 0;
    win_axis = 1'b0;
    win_sat = 1'b0;
  endfunction

  // fold, offset, scale and arcsine of one code, then the window average
  function automatic void predict_tilt(input logic [10:0] code, input logic axis);
    int           folded;
    int           offset;
    int           diff;
    int           mag;
    int           sens;
    int           idx;
    int           ang;
    logic         clamped;
    longint       rounded;
    tilt_result_t res;
    folded = int'(code);
    if (folded > int'(fold_high_q)) begin
      folded = 2 * int'(fold_high_q) - folded;
    end else if (folded < int'(fold_low_q)) begin
      folded = 2 * int'(fold_low_q) - folded;
    end
    offset = int'(zero_code_q) + (axis ? int'(trim_b_q) : int'(trim_a_q));
    diff = folded - offset;
    mag = (diff < 0) ? -diff : diff;
    sens = (sens_q == 0) ? 1 : int'(sens_q);
    clamped = (mag > sens);
    if (clamped) begin
      idx = LUT_DEPTH;
    end else begin
      idx = (mag * 2 * LUT_DEPTH + sens) / (2 * sens);
      if (idx > LUT_DEPTH) begin
        idx = LUT_DEPTH;
      end
    end
    ang = (diff < 0) ? -asin_lut[idx] : asin_lut[idx];

    // pass-through: each sample is a result and drops any partial window
    if (!filter_q) begin
      clear_window();
      res.angle = ang[ANGLE_W-1:0];
      res.axis = axis;
      res.sat = clamped;
      angle_expect_q.push_back(res);
      return;
    end

    // axis change restarts the window with this sample
    if (taps_seen != 0 && axis != win_axis) begin
      clear_window();
    end
    if (taps_seen == 0) begin
      win_axis = axis;
    end
    win_sum += longint'(ang) * longint'(WEIGHTS[taps_seen]);
    win_sat |= clamped;
    taps_seen++;
    if (taps_seen == TAPS) begin
      rounded = (win_sum + 64'sd32768) >>> FRAC_W;
      if (rounded > longint'(QUARTER_TURN)) begin
        rounded = longint'(QUARTER_TURN);
      end else if (rounded < -longint'(QUARTER_TURN)) begin
        rounded = -longint'(QUARTER_TURN);
      end
      res.angle = rounded[ANGLE_W-1:0];
      res.axis = win_axis;
      res.sat = win_sat;
      angle_expect_q.push_back(res);
      clear_window();
    end
  endfunction

  function automatic logic [31:0] reg_mask(input int idx);
    case (idx)
      REG_TRIM_AXIS_A, REG_TRIM_AXIS_B: return 32'h0000_00ff;
      REG_FILTER_ON:                    return 32'h0000_0001;
      default:                          return 32'h0000_07ff;
    endcase
  endfunction

  // most gaps short, a few long
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return int'($urandom_range(1, 2));
    end else if (r < 95) begin
      return int'($urandom_range(3, 6));
    end
    return int'($urandom_range(10, 40));
  endfunction

  // code near the live range, anywhere, at the extremes or around a fold limit
  function automatic logic [10:0] pick_code(input logic axis);
    int          center;
    int          span;
    int          c;
    int unsigned pick;
    span = (sens_q == 0) ? 1 : int'(sens_q);
    center = int'(zero_code_q) + (axis ? int'(trim_b_q) : int'(trim_a_q));
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      c = center + int'($urandom_range(0, 2 * span + 8)) - (span + 4);
    end else if (pick < 7) begin
      c = int'($urandom_range(0, CODE_MAX));
    end else if (pick == 7) begin
      c = $urandom_range(0, 1) ? CODE_MAX : 0;
    end else if (pick == 8) begin
      c = int'(fold_high_q) + int'($urandom_range(0, 40)) - 8;
    end else begin
      c = int'(fold_low_q) - int'($urandom_range(0, 40)) + 8;
    end
    if (c < 0) begin
      c = 0;
    end else if (c > CODE_MAX) begin
      c = CODE_MAX;
    end
    return c[10:0];
  endfunction

  // one apb transfer: setup cycle, then access cycle
  task automatic apb_access(input logic wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, mirror it in the model and read it back when idx < REG_COUNT
  task automatic set_reg(input int idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    reg_writes++;
    case (idx)
      REG_ZERO_CODE:   zero_code_q = value[10:0];
      REG_TRIM_AXIS_A: trim_a_q = value[7:0];
      REG_TRIM_AXIS_B: trim_b_q = value[7:0];
      REG_FOLD_HIGH:   fold_high_q = value[10:0];
      REG_FOLD_LOW:    fold_low_q = value[10:0];
      REG_SENSITIVITY: sens_q = value[10:0];
      REG_FILTER_ON:   filter_q = value[0];
      default: ;
    endcase
    if (idx < REG_COUNT) begin
      apb_access(1'b0, idx, '0, rd);
      if ((rd & reg_mask(idx)) != (value & reg_mask(idx))) begin
        $display("%0t: register %0d read back expected 0x%0h actual 0x%0h",
                 $time, idx, value & reg_mask(idx), rd & reg_mask(idx));
        errors++;
      end
    end
  endtask

  task automatic set_all(input logic [10:0] zc, input logic [7:0] ta, input logic [7:0] tb,
                         input logic [10:0] fh, input logic [10:0] fl,
                         input logic [10:0] sv, input logic fo);
    set_reg(REG_ZERO_CODE, 32'(zc));
    set_reg(REG_TRIM_AXIS_A, 32'(ta));
    set_reg(REG_TRIM_AXIS_B, 32'(tb));
    set_reg(REG_FOLD_HIGH, 32'(fh));
    set_reg(REG_FOLD_LOW, 32'(fl));
    set_reg(REG_SENSITIVITY, 32'(sv));
    set_reg(REG_FILTER_ON, 32'(fo));
  endtask

  task automatic push_sample(input int code, input logic axis);
    tilt_sample_t s;
    s.code = code[10:0];
    s.axis = axis;
    sample_q.push_back(s);
  endtask

  // wait for all transfers and results, then for the back end to drain
  task automatic settle();
    while (sample_q.size() != 0 || in_valid || angle_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random part: mostly whole windows of one axis, some broken ones
  task automatic queue_phase(input int count);
    int   made;
    int   seg_len;
    logic ax;
    made = 0;
    while (made < count) begin
      ax = $urandom_range(0, 1);
      if (!filter_q) begin
        seg_len = 1;
      end else if ($urandom_range(0, 4) != 0) begin
        seg_len = TAPS * int'($urandom_range(1, 3));
      end else begin
        seg_len = int'($urandom_range(1, TAPS - 1));
      end
      repeat (seg_len) begin
        push_sample(int'(pick_code(ax)), ax);
        made++;
      end
    end
  endtask

  // input side: predict on each transfer
  always @(posedge clk) begin
    sample_done <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      predict_tilt(raw_code, axis_select);
      samples_taken++;
    end
  end

  // input driver, changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !sample_done) begin
      // hold until the transfer
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (sample_q.size() != 0) begin
      next_sample = sample_q.pop_front();
      raw_code <= next_sample.code;
      axis_select <= next_sample.axis;
      in_valid <= 1'b1;
      send_gap = (pace_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side: random receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (pace_on && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_result.angle = angle_value;
      got_result.axis = axis_out;
      got_result.sat = saturated;
      if (angle_expect_q.size() == 0) begin
        $display("%0t: unexpected result angle %0d axis %0b saturated %0b",
                 $time, got_result.angle, got_result.axis, got_result.sat);
        errors++;
      end else begin
        want_result = angle_expect_q.pop_front();
        results_checked++;
        if (want_result.sat) begin
          sat_results++;
        end
        if (got_result.angle !== want_result.angle) begin
          $display("%0t: angle_value expected %0d actual %0d",
                   $time, want_result.angle, got_result.angle);
          errors++;
        end
        if (got_result.axis !== want_result.axis) begin
          $display("%0t: axis_out expected %0b actual %0b",
                   $time, want_result.axis, got_result.axis);
          errors++;
        end
        if (got_result.sat !== want_result.sat) begin
          $display("%0t: saturated expected %0b actual %0b",
                   $time, want_result.sat, got_result.sat);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, angle_expect_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // sequence of phases
  initial begin
    logic [10:0] zc;
    logic [10:0] fh;
    logic [10:0] fl;
    logic [10:0] sv;
    logic [7:0]  ta;
    logic [7:0]  tb;
    fill_asin_lut();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // pass-through at reset settings: code extremes, both axes
    set_reg(REG_FILTER_ON, 32'd0);
    push_sample(0, 1'b0);
    push_sample(CODE_MAX, 1'b1);
    push_sample(1024, 1'b0);
    push_sample(1023, 1'b1);
    settle();

    // folds beyond range, extreme trims, zero sensitivity, write past the last register
    set_all(11'd0, 8'h7f, 8'h80, 11'd1500, 11'd300, 11'd0, 1'b0);
    set_reg(REG_COUNT, 32'hffff_ffff);
    push_sample(CODE_MAX, 1'b0);
    push_sample(0, 1'b1);
    push_sample(1500, 1'b1);
    push_sample(127, 1'b0);
    settle();

    // window: partial window of one axis cut by a full window of the other
    set_all(11'd1024, 8'h00, 8'h00, 11'd2047, 11'd0, 11'd1638, 1'b1);
    push_sample(CODE_MAX, 1'b1);
    push_sample(0, 1'b1);
    push_sample(2000, 1'b1);
    for (int i = 0; i < TAPS; i++) begin
      push_sample((i % 4 == 0) ? CODE_MAX : (i % 4 == 2) ? 0 : 1024 + 90 * i, 1'b0);
    end
    settle();

    // random phases, the first ones at the register extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      pace_on = (ph % 4 != 3);
      case (ph)
        0: set_all(11'd0, 8'h7f, 8'h80, 11'd2047, 11'd0, 11'd1, 1'b1);
        1: set_all(11'd2047, 8'h80, 8'h7f, 11'd0, 11'd2047, 11'd2047, 1'b0);
        default: begin
          zc = $urandom_range(0, 5) == 0 ? 11'($urandom_range(0, CODE_MAX))
                                         : 11'($urandom_range(400, 1600));
          ta = $urandom_range(0, 255);
          tb = $urandom_range(0, 255);
          fh = $urandom_range(0, 1) ? 11'(CODE_MAX) : 11'($urandom_range(1200, CODE_MAX));
          fl = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(0, 800));
          sv = $urandom_range(0, 3) == 0 ? 11'($urandom_range(1, CODE_MAX))
                                         : 11'($urandom_range(300, 1200));
          set_all(zc, ta, tb, fh, fl, sv, ph % 3 != 2);
        end
      endcase
      queue_phase(PHASE_LEN);
      settle();
    end

    $display("covered %0d samples and %0d checked results, %0d of them saturated",
             samples_taken, results_checked, sat_results);
    $display("%0d register writes over %0d setting phases, filter on and off",
             reg_writes, PHASES + 3);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
